@@ rtl/cspg_pkg.sv @@
// Package for the counted step pulse generator core.
// Holds command codes, sequencer states, constants and payload structs.
// No dependencies.
package cspg_pkg;

  localparam int unsigned HzWidth    = 20;
  localparam int unsigned StepsWidth = 32;
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned BitIdxWidth = 5;

  localparam logic [HzWidth-1:0]   TICKS_PER_SEC = 20'd1000000;
  localparam logic [HzWidth-1:0]   PERIOD_MIN    = 20'd2;
  localparam logic [HzWidth-1:0]   PERIOD_MAX    = 20'd65535;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_SET_PINS = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_ENABLE_ACTIVE_LOW = 1'b0,
    REG_DIRECTION_INVERT  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [StepsWidth-1:0] step_count;
    logic [HzWidth-1:0]    step_rate_hz;
    logic                  dir_positive;
    logic                  enable_request;
  } in_item_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic enable_level;
    logic busy_res;
    logic done_res;
    logic accepted;
  } out_item_t;

endpackage

@@ rtl/counted_step_pulse_generator_core.sv @@
// Counted step pulse generator top level: command decode, tick logic,
// bit-serial period divider and result register.
// Depends on cspg_pkg.

// One transfer in gives one transfer out. Ticks, pin updates, refused moves
// and unused commands are accepted in the idle state and present the result
// on the next cycle; no new item is taken until that result transfer is done.
// An accepted move runs the period divide 1000000 / step_rate_hz through a
// restoring divider that resolves one quotient bit per cycle, and registers
// the result when the last bit is resolved. The input is stalled from accept
// until the result transfer completes.
module counted_step_pulse_generator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cspg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cspg_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data
);
  import cspg_pkg::*;

  state_t state, state_next;

  logic enable_active_low;
  logic direction_invert;

  logic [TickWidth-1:0]  period_ticks;
  logic [TickWidth-1:0]  high_ticks;
  logic [TickWidth-1:0]  tick_counter;
  logic [StepsWidth-1:0] steps_left;
  logic                  moving_flag;
  logic                  dir_pin;
  logic                  enable_pin;

  logic [HzWidth-1:0]     div_hz;
  logic [StepsWidth-1:0]  pend_steps;
  logic [HzWidth-1:0]     rem;
  logic [HzWidth-1:0]     quo;
  logic [BitIdxWidth-1:0] bit_idx;

  logic             in_fire;
  logic             move_ok;
  logic             cur_level;
  logic             wrap;
  logic [TickWidth:0] tick_inc;
  logic [StepsWidth-1:0] steps_dec;

  logic [HzWidth:0]   r_sh;
  logic               fits;
  logic [HzWidth:0]   r_new;
  logic [HzWidth-1:0] quo_new;
  logic [HzWidth-1:0] period_full;
  logic [TickWidth-1:0] period_new;

  out_item_t idle_res;
  out_item_t div_res;

  assign in_fire   = in_valid && !in_stall;
  assign move_ok   = !moving_flag && (in_data.step_count != '0) && (in_data.step_rate_hz != '0);
  assign cur_level = moving_flag && (tick_counter < high_ticks);
  assign tick_inc  = {1'b0, tick_counter} + {{TickWidth{1'b0}}, 1'b1};
  assign wrap      = tick_inc >= {1'b0, period_ticks};
  assign steps_dec = (steps_left != '0) ? steps_left - StepsWidth'(1) : steps_left;

  // One restoring divide step
  assign r_sh    = {rem, TICKS_PER_SEC[bit_idx]};
  assign fits    = r_sh >= {1'b0, div_hz};
  assign r_new   = fits ? r_sh - {1'b0, div_hz} : r_sh;
  assign quo_new = {quo[HzWidth-2:0], fits};

  always_comb begin
    period_full = quo_new;
    if (quo_new < PERIOD_MIN) begin
      period_full = PERIOD_MIN;
    end else if (quo_new > PERIOD_MAX) begin
      period_full = PERIOD_MAX;
    end
    period_new = period_full[TickWidth-1:0];
  end

  always_comb begin
    idle_res              = '0;
    idle_res.step_level   = cur_level;
    idle_res.dir_level    = dir_pin;
    idle_res.enable_level = enable_pin;
    idle_res.busy_res     = moving_flag;
    case (in_data.cmd)
      CMD_TICK: begin
        if (moving_flag && wrap && (steps_dec == '0)) begin
          idle_res.busy_res = 1'b0;
          idle_res.done_res = 1'b1;
        end
      end
      CMD_SET_PINS: begin
        idle_res.dir_level    = in_data.dir_positive ^ direction_invert;
        idle_res.enable_level = in_data.enable_request ^ enable_active_low;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_res              = '0;
    div_res.step_level   = ((period_new >> 1) != '0);
    div_res.dir_level    = dir_pin;
    div_res.enable_level = enable_pin;
    div_res.busy_res     = 1'b1;
    div_res.accepted     = 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_MOVE && move_ok) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_DIV: begin
        if (bit_idx == '0) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_RESP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      enable_active_low <= 1'b1;
      direction_invert  <= 1'b0;
      period_ticks      <= '0;
      high_ticks        <= '0;
      tick_counter      <= '0;
      steps_left        <= '0;
      moving_flag       <= 1'b0;
      dir_pin           <= 1'b1;
      enable_pin        <= 1'b1;
      bit_idx           <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE_ACTIVE_LOW: enable_active_low <= cfg_data;
          REG_DIRECTION_INVERT:  direction_invert  <= cfg_data;
          default: ;
        endcase
      end

      if (state == ST_IDLE && in_fire) begin
        out_data <= idle_res;
        case (in_data.cmd)
          CMD_TICK: begin
            if (moving_flag) begin
              if (wrap) begin
                tick_counter <= '0;
                steps_left   <= steps_dec;
                if (steps_dec == '0) begin
                  moving_flag <= 1'b0;
                end
              end else begin
                tick_counter <= tick_inc[TickWidth-1:0];
              end
            end
          end
          CMD_MOVE: begin
            if (move_ok) begin
              div_hz     <= in_data.step_rate_hz;
              pend_steps <= in_data.step_count;
              rem        <= '0;
              quo        <= '0;
              bit_idx    <= BitIdxWidth'(HzWidth - 1);
            end
          end
          CMD_SET_PINS: begin
            dir_pin    <= in_data.dir_positive ^ direction_invert;
            enable_pin <= in_data.enable_request ^ enable_active_low;
          end
          default: ;
        endcase
      end

      if (state == ST_DIV) begin
        rem     <= r_new[HzWidth-1:0];
        quo     <= quo_new;
        bit_idx <= bit_idx - BitIdxWidth'(1);
        if (bit_idx == '0) begin
          period_ticks <= period_new;
          high_ticks   <= period_new >> 1;
          tick_counter <= '0;
          steps_left   <= pend_steps;
          moving_flag  <= 1'b1;
          out_data     <= div_res;
        end
      end
    end
  end

  a_period_valid: assert property (@(posedge clk) disable iff (rst)
    moving_flag |-> (period_ticks >= TickWidth'(2)) && (high_ticks == (period_ticks >> 1)))
    else $error("period out of range while moving");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    moving_flag |-> tick_counter < period_ticks)
    else $error("tick counter beyond period");

  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res && !moving_flag)
    else $error("done reported while still moving");

  a_div_holds_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> in_stall && !out_valid)
    else $error("handshake open during divide");

endmodule

@@ sim/cspg_checker.sv @@
// Transfer checker for the counted step pulse generator core.
// Watches both channels and the register port, predicts each result and compares it.
// Depends on cspg_pkg.
module cspg_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cspg_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cspg_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output int unsigned         fault_count,
  output int unsigned         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cspg_pkg::*;

  logic        en_active_low;
  logic        dir_flip;
  logic [15:0] period;
  logic [15:0] half_period;
  logic [15:0] phase;
  logic [31:0] steps_left;
  logic        moving;
  logic        dir_pin;
  logic        en_pin;
  out_item_t   pin_forecast[$];
  int unsigned mismatches = 0;
  int unsigned result_no = 0;

  initial begin
    fault_count = 0;
    outstanding = 0;
  end

  task automatic report(string msg);
    $display("cspg_checker: %s", msg);
    mismatches++;
  endtask

  task automatic check_bit(string name, logic got, logic want);
    if (got !== want) begin
      report($sformatf("result %0d %s got %b want %b", result_no, name, got, want));
    end
  endtask

  function automatic logic [15:0] period_for(logic [19:0] hz);
    int unsigned q;
    q = 1_000_000 / hz;
    if (q < 2) q = 2;
    else if (q > 32'hFFFF) q = 32'hFFFF;
    return 16'(q);
  endfunction

  function automatic out_item_t advance_axis(in_item_t it);
    out_item_t r;
    r = '0;
    r.step_level = moving && (phase < half_period);
    case (cmd_t'(it.cmd))
      CMD_TICK: begin
        if (moving) begin
          if (32'(phase) + 1 >= 32'(period)) begin
            phase = '0;
            if (steps_left != 0) steps_left--;
            if (steps_left == 0) begin
              moving = 1'b0;
              r.done_res = 1'b1;
            end
          end else begin
            phase++;
          end
        end
      end
      CMD_MOVE: begin
        if (!moving && it.step_count != 0 && it.step_rate_hz != 0) begin
          period = period_for(it.step_rate_hz);
          half_period = period >> 1;
          phase = '0;
          steps_left = it.step_count;
          moving = 1'b1;
          r.accepted = 1'b1;
        end
        r.step_level = moving && (phase < half_period);
      end
      CMD_SET_PINS: begin
        dir_pin = it.dir_positive ^ dir_flip;
        en_pin = it.enable_request ^ en_active_low;
      end
      default: begin
      end
    endcase
    r.dir_level = dir_pin;
    r.enable_level = en_pin;
    r.busy_res = moving;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      en_active_low = 1'b1;
      dir_flip = 1'b0;
      period = '0;
      half_period = '0;
      phase = '0;
      steps_left = '0;
      moving = 1'b0;
      dir_pin = 1'b1;
      en_pin = 1'b1;
      pin_forecast.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_ENABLE_ACTIVE_LOW: en_active_low = cfg_data;
          REG_DIRECTION_INVERT:  dir_flip = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pin_forecast.size() == 0) begin
          report($sformatf("result %0d arrived with nothing outstanding", result_no));
        end else begin
          want = pin_forecast.pop_front();
          check_bit("step_level", out_data.step_level, want.step_level);
          check_bit("dir_level", out_data.dir_level, want.dir_level);
          check_bit("enable_level", out_data.enable_level, want.enable_level);
          check_bit("busy_res", out_data.busy_res, want.busy_res);
          check_bit("done_res", out_data.done_res, want.done_res);
          check_bit("accepted", out_data.accepted, want.accepted);
        end
        result_no++;
      end
      if (in_valid && !in_stall) pin_forecast.push_back(advance_axis(in_data));
    end
    fault_count <= mismatches;
    outstanding <= pin_forecast.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the counted step pulse generator core.
// Drives commands, register writes and receiver stalls; cspg_checker does the comparing.
// Depends on cspg_pkg, counted_step_pulse_generator_core and cspg_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cspg_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PhaseItems = 210;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;
  int unsigned fault_count;
  int unsigned outstanding;

  logic        rush = 1'b0;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned quiet_left = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;

  counted_step_pulse_generator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cspg_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: short stalls, long open stretches, one long hold-off on request
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(99);
    if (rst || rush) begin
      out_stall <= 1'b0;
      seg_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (seg_left != 0) begin
      seg_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      seg_left = (r < 80) ? $urandom_range(7) :
                 (r < 95) ? $urandom_range(39, 8) : $urandom_range(299, 99);
    end else begin
      out_stall <= 1'b1;
      seg_left = (r < 85) ? $urandom_range(2) : $urandom_range(39, 9);
    end
  end

  function automatic in_item_t noise_fields(cmd_t c);
    in_item_t it;
    it.cmd = c;
    it.step_count = $urandom();
    it.step_rate_hz = 20'($urandom());
    it.dir_positive = 1'($urandom());
    it.enable_request = 1'($urandom());
    return it;
  endfunction

  function automatic in_item_t make_item(cmd_t c, logic [31:0] n, logic [19:0] hz,
                                         logic d, logic e);
    in_item_t it;
    it.cmd = c;
    it.step_count = n;
    it.step_rate_hz = hz;
    it.dir_positive = d;
    it.enable_request = e;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (rush) return 0;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if (r < 2) begin
      quiet_left = $urandom_range(80, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic tick_run(int unsigned count);
    repeat (count) push_item(noise_fields(CMD_TICK));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic en_low, logic dir_inv);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE_ACTIVE_LOW;
    cfg_data <= en_low;
    @(posedge clk);
    cfg_index <= REG_DIRECTION_INVERT;
    cfg_data <= dir_inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_noise();
    in_item_t it;
    case ($urandom_range(3))
      0: it = noise_fields(CMD_TICK);
      1: it = noise_fields(CMD_SET_PINS);
      2: it = noise_fields(CMD_UNUSED);
      default: begin
        it = noise_fields(CMD_MOVE);
        if ($urandom_range(1) != 0) it.step_count = '0;
        else it.step_rate_hz = '0;
      end
    endcase
    push_item(it);
  endtask

  // one accepted move, ticked through to its last step, with refused moves,
  // pin updates and unused commands mixed in while it runs
  task automatic run_move();
    in_item_t    it;
    int unsigned r;
    int unsigned p;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 80) p = $urandom_range(12, 2);
    else if (r < 97) p = $urandom_range(200, 13);
    else p = $urandom_range(400, 201);
    lo = 1_000_000 / (p + 1) + 1;
    hi = (p == 2) ? 32'hFFFFF : 1_000_000 / p;
    n = (p <= 12) ? $urandom_range(5, 1) : 1;
    it = noise_fields(CMD_MOVE);
    it.step_count = n;
    it.step_rate_hz = 20'($urandom_range(hi, lo));
    p = 1_000_000 / it.step_rate_hz;
    if (p < 2) p = 2;
    if ($urandom_range(9) < 3) push_item(noise_fields(CMD_SET_PINS));
    push_item(it);
    for (k = 0; k < p * n; k++) begin
      if ($urandom_range(99) < 8) push_item(noise_fields(cmd_t'($urandom_range(3, 1))));
      push_item(noise_fields(CMD_TICK));
    end
    tick_run($urandom_range(2));
  endtask

  initial begin
    int unsigned ph;
    int unsigned goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_regs(1'b1, 1'b0);

    push_item(noise_fields(CMD_TICK));
    push_item(noise_fields(CMD_UNUSED));
    push_item(make_item(CMD_SET_PINS, '0, '0, 1'b1, 1'b1));
    push_item(make_item(CMD_SET_PINS, '1, '1, 1'b0, 1'b0));
    push_item(make_item(CMD_MOVE, 32'd0, 20'd1000, 1'b1, 1'b1));
    push_item(make_item(CMD_MOVE, 32'd5, 20'd0, 1'b0, 1'b0));
    push_item(make_item(CMD_MOVE, 32'd1, 20'd500000, 1'b0, 1'b1));
    push_item(make_item(CMD_MOVE, '1, '1, 1'b1, 1'b0));
    push_item(make_item(CMD_SET_PINS, '0, '0, 1'b1, 1'b1));
    tick_run(2);
    push_item(make_item(CMD_MOVE, 32'd2, '1, 1'b0, 1'b0));
    tick_run(4);
    push_item(make_item(CMD_MOVE, 32'd1, 20'd333333, 1'b1, 1'b1));
    tick_run(3);
    settle();
    write_regs(1'b0, 1'b1);
    push_item(noise_fields(CMD_TICK));
    push_item(make_item(CMD_SET_PINS, '0, '0, 1'b1, 1'b0));

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_regs(1'b0, 1'b0);
        1: write_regs(1'b1, 1'b1);
        2: write_regs(1'b1, 1'b0);
        3: write_regs(1'b0, 1'b1);
        default: write_regs(1'($urandom()), 1'($urandom()));
      endcase
      if (ph == 2) hold_req <= 1'b1;
      goal = sent + PhaseItems;
      while (sent < goal) begin
        if ($urandom_range(3) == 0) idle_noise();
        else run_move();
      end
    end

    // slowest rate: period clamps to its maximum; leave it running back to
    // back so the later moves are refused
    rush <= 1'b1;
    settle();
    write_regs(1'b1, 1'b1);
    push_item(make_item(CMD_MOVE, 32'd1, 20'd15, 1'b0, 1'b0));
    tick_run(8);
    rush <= 1'b0;
    push_item(make_item(CMD_MOVE, '1, '1, 1'b1, 1'b1));
    tick_run(8);
    push_item(make_item(CMD_MOVE, 32'd7, 20'd1000, 1'b0, 1'b0));
    settle();
    repeat (30) @(posedge clk);
    if (fault_count == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
